// File: rtl/rlpd_pkg.sv
// shared types and constants of the run-length pixel decoder
package rlpd_pkg;

	localparam int BYTE_W  = 8;
	localparam int CODE_W  = 5;
	localparam int COUNT_W = 14;
	localparam int START_W = 24;
	localparam int DIM_W   = 12;
	localparam int TOTAL_W = 2 * DIM_W;
	localparam int CFG_IDX_W = 1;

	localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 1'd1;

	localparam logic [DIM_W-1:0] WIDTH_RESET  = 12'd64;
	localparam logic [DIM_W-1:0] HEIGHT_RESET = 12'd64;

	localparam logic [BYTE_W-1:0] CODE_EXTRA = 8'hc0;
	localparam logic [2:0] KIND_COLOR_LONG = 3'b100;
	localparam logic [2:0] KIND_BG_LONG    = 3'b101;
	localparam logic [2:0] KIND_LIT_SHORT  = 3'b110;

	localparam logic [CODE_W-1:0] EXTRA_CODE = 5'd17;
	localparam logic [CODE_W-1:0] BG_CODE    = 5'd0;

	typedef enum logic [1:0] {
		PH_CODE    = 2'd0,
		PH_HEADER  = 2'd1,
		PH_LITERAL = 2'd2
	} phase_t;

	// one decoded run handed from front to back
	typedef struct packed {
		logic [CODE_W-1:0]  c1;
		logic [CODE_W-1:0]  c2;
		logic [COUNT_W-1:0] count;
		logic               last;
		logic               cut;
	} run_rec_t;

	typedef struct packed {
		logic       full;
		logic       empty;
		logic [1:0] count;
	} fifo_stat_t;

endpackage

// File: rtl/rlpd_byte_if.sv
// byte stream channel
interface rlpd_byte_if;
	logic                        valid;
	logic                        ready;
	logic [rlpd_pkg::BYTE_W-1:0] data_byte;
	logic                        last_byte;

	modport source (output valid, output data_byte, output last_byte, input ready);
	modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

// File: rtl/rlpd_run_if.sv
// run result channel
interface rlpd_run_if;
	logic                         valid;
	logic                         ready;
	logic [rlpd_pkg::CODE_W-1:0]  first_code;
	logic [rlpd_pkg::CODE_W-1:0]  second_code;
	logic [rlpd_pkg::COUNT_W-1:0] pixel_count;
	logic [rlpd_pkg::START_W-1:0] start_offset;
	logic                         image_done;
	logic                         truncated;

	modport source (output valid, output first_code, output second_code,
		output pixel_count, output start_offset, output image_done,
		output truncated, input ready);
	modport sink (input valid, input first_code, input second_code,
		input pixel_count, input start_offset, input image_done,
		input truncated, output ready);
endinterface

// File: rtl/run_length_pixel_decoder_top.sv
// top level of the run-length pixel decoder
//
//  channel   dir  word                                       accepted when
//  stream    in   data_byte, last_byte                       valid && ready
//  runs      out  first_code, second_code, pixel_count,      valid && ready
//                 start_offset, image_done, truncated
//  wr_*      in   wr_index, wr_data                          wr_en
//
// one byte per cycle while the run queue is not full; a result is decoded from its
// byte, held in the run queue and then placed into the output register
// the front decoder stalls only when the two-word run queue is full
// the run queue and output register let the stream run while runs waits
// reset clears decode state, position, queue and output valid; sizes go to 64x64
// width and height reach the end-of-image compare through their registers and then the registered product
module run_length_pixel_decoder_top #(
	parameter int PALETTE_SIZE = 16,
	parameter int POSITION_BITS = 24
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            wr_en,
	input  logic [rlpd_pkg::CFG_IDX_W-1:0]  wr_index,
	input  logic [rlpd_pkg::DIM_W-1:0]      wr_data,
	rlpd_byte_if.sink                       stream,
	rlpd_run_if.source                      runs
);
	import rlpd_pkg::*;

	run_rec_t   push_rec;
	run_rec_t   head_rec;
	fifo_stat_t q_stat;
	logic       push;
	logic       pop;

	rlpd_front #(
		.PALETTE_SIZE(PALETTE_SIZE)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.stream(stream),
		.q_full(q_stat.full),
		.push(push),
		.rec(push_rec)
	);

	rlpd_fifo u_fifo (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.wr_rec(push_rec),
		.pop(pop),
		.rd_rec(head_rec),
		.stat(q_stat)
	);

	rlpd_back #(
		.POSITION_BITS(POSITION_BITS)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.wr_en(wr_en),
		.wr_index(wr_index),
		.wr_data(wr_data),
		.rec(head_rec),
		.rec_valid(!q_stat.empty),
		.pop(pop),
		.runs(runs)
	);

	a_q_bound: assert property (@(posedge clk) disable iff (!arst_n)
		q_stat.count != 2'd3)
		else $error("run queue count out of range");

	a_q_ready: assert property (@(posedge clk) disable iff (!arst_n)
		stream.ready == !q_stat.full)
		else $error("stream ready disagrees with queue state");

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_stat.full && !pop |=> q_stat.full)
		else $error("queue lost a word");

	a_run_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		runs.valid && !runs.truncated |-> runs.pixel_count != 14'd0)
		else $error("complete run with no pixels");

	a_extra_single: assert property (@(posedge clk) disable iff (!arst_n)
		runs.valid && runs.first_code == EXTRA_CODE |->
			runs.pixel_count == 14'd1 && runs.second_code == EXTRA_CODE)
		else $error("extra colour run not a single pixel");

endmodule

// File: rtl/rlpd_front.sv
// front end: takes stream bytes and decodes them into run records
module rlpd_front #(
	parameter int PALETTE_SIZE = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	rlpd_byte_if.sink           stream,
	input  logic                q_full,
	output logic                push,
	output rlpd_pkg::run_rec_t  rec
);
	import rlpd_pkg::*;

	phase_t              phase_q, phase_d;
	logic [BYTE_W-1:0]   held_q, held_d;
	logic [COUNT_W-1:0]  left_q, left_d;
	logic                accept;
	logic                have;
	logic [BYTE_W-1:0]   b;
	logic [4:0]          top;
	logic [COUNT_W-1:0]  hdr_n;

	function automatic logic [CODE_W-1:0] pal_code(input logic [3:0] idx);
		logic [3:0] i;
		i = idx;
		if ({1'b0, idx} >= CODE_W'(PALETTE_SIZE))
			i = 4'(PALETTE_SIZE - 1);
		return {1'b0, i} + 5'd1;
	endfunction

	assign stream.ready = !q_full;
	assign accept = stream.valid && stream.ready;
	assign b = stream.data_byte;
	assign top = held_q[4:0];
	// 13-bit length field of a long header, plus one
	assign hdr_n = {1'b0, top, b} + 14'd1;

	// next state
	always_comb begin
		phase_d = phase_q;
		held_d = held_q;
		left_d = left_q;
		case (phase_q)
			PH_HEADER: begin
				if (held_q[7:5] == KIND_COLOR_LONG || held_q[7:5] == KIND_BG_LONG) begin
					phase_d = PH_CODE;
				end else begin
					left_d = hdr_n;
					phase_d = PH_LITERAL;
				end
			end
			PH_LITERAL: begin
				if (left_q >= 14'd2)
					left_d = left_q - 14'd2;
				else
					left_d = '0;
				if (left_d == '0)
					phase_d = PH_CODE;
			end
			default: begin
				phase_d = PH_CODE;
				if (b != CODE_EXTRA && b[7]) begin
					if (b[7:5] == KIND_LIT_SHORT) begin
						left_d = {9'd0, b[4:0]} + 14'd1;
						phase_d = PH_LITERAL;
					end else begin
						held_d = b;
						phase_d = PH_HEADER;
					end
				end
			end
		endcase
		if (stream.last_byte) begin
			phase_d = PH_CODE;
			held_d = '0;
			left_d = '0;
		end
	end

	// record out
	always_comb begin
		have = 1'b0;
		rec.c1 = BG_CODE;
		rec.c2 = BG_CODE;
		rec.count = '0;
		case (phase_q)
			PH_HEADER: begin
				if (held_q[7:5] == KIND_COLOR_LONG) begin
					have = 1'b1;
					rec.c1 = pal_code(b[3:0]);
					rec.c2 = rec.c1;
					rec.count = {5'd0, top, b[7:4]} + 14'd1;
				end else if (held_q[7:5] == KIND_BG_LONG) begin
					have = 1'b1;
					rec.count = hdr_n;
				end
			end
			PH_LITERAL: begin
				have = 1'b1;
				rec.c1 = pal_code(b[3:0]);
				if (left_q >= 14'd2) begin
					rec.c2 = pal_code(b[7:4]);
					rec.count = 14'd2;
				end else begin
					rec.c2 = rec.c1;
					rec.count = 14'd1;
				end
			end
			default: begin
				if (b == CODE_EXTRA) begin
					have = 1'b1;
					rec.c1 = EXTRA_CODE;
					rec.c2 = EXTRA_CODE;
					rec.count = 14'd1;
				end else if (!b[7]) begin
					have = 1'b1;
					rec.c1 = pal_code(b[3:0]);
					rec.c2 = rec.c1;
					rec.count = {11'd0, b[6:4]} + 14'd1;
				end
			end
		endcase
		rec.last = stream.last_byte;
		// stream ends with a code still open
		rec.cut = stream.last_byte && (phase_q == PH_HEADER ||
			(phase_q == PH_LITERAL && rec.count != 14'd1 && left_q != 14'd2) ||
			(phase_q != PH_HEADER && phase_q != PH_LITERAL && !have));
		if (phase_q == PH_HEADER && held_q[7:5] != KIND_LIT_SHORT &&
			(held_q[7:5] == KIND_COLOR_LONG || held_q[7:5] == KIND_BG_LONG))
			rec.cut = 1'b0;
		push = accept && (have || rec.cut);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_CODE;
			held_q <= '0;
			left_q <= '0;
		end else if (accept) begin
			phase_q <= phase_d;
			held_q <= held_d;
			left_q <= left_d;
		end
	end

endmodule

// File: rtl/rlpd_fifo.sv
// two-word queue of run records between front and back
module rlpd_fifo (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  rlpd_pkg::run_rec_t    wr_rec,
	input  logic                  pop,
	output rlpd_pkg::run_rec_t    rd_rec,
	output rlpd_pkg::fifo_stat_t  stat
);
	import rlpd_pkg::*;

	run_rec_t   mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;

	assign rd_rec = mem_q[rd_ptr_q];
	assign stat.count = count_q;
	assign stat.full = (count_q == 2'd2);
	assign stat.empty = (count_q == 2'd0);

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= wr_rec;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (push)
				wr_ptr_q <= !wr_ptr_q;
			if (pop)
				rd_ptr_q <= !rd_ptr_q;
			case ({push, pop})
				2'b10: count_q <= count_q + 2'd1;
				2'b01: count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// File: rtl/rlpd_back.sv
// back end: places runs in the image and registers the result word
module rlpd_back #(
	parameter int POSITION_BITS = 24
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              wr_en,
	input  logic [rlpd_pkg::CFG_IDX_W-1:0]    wr_index,
	input  logic [rlpd_pkg::DIM_W-1:0]        wr_data,
	input  rlpd_pkg::run_rec_t                rec,
	input  logic                              rec_valid,
	output logic                              pop,
	rlpd_run_if.source                        runs
);
	import rlpd_pkg::*;

	localparam int SUM_W = (POSITION_BITS + 1 > TOTAL_W) ? POSITION_BITS + 1 : TOTAL_W;
	localparam int EXT_W = (POSITION_BITS > START_W) ? POSITION_BITS : START_W;

	logic [DIM_W-1:0]         width_q;
	logic [DIM_W-1:0]         height_q;
	logic [TOTAL_W-1:0]       total_q;
	logic [POSITION_BITS-1:0] pos_q;
	logic [SUM_W-1:0]         sum;
	logic [EXT_W-1:0]         start_ext;
	logic                     valid_q;

	assign pop = rec_valid && (!valid_q || runs.ready);
	assign sum = SUM_W'(pos_q) + SUM_W'(rec.count);
	assign start_ext = EXT_W'(pos_q);
	assign runs.valid = valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q <= WIDTH_RESET;
			height_q <= HEIGHT_RESET;
		end else if (wr_en) begin
			case (wr_index)
				REG_WIDTH: width_q <= wr_data;
				REG_HEIGHT: height_q <= wr_data;
				default: ;
			endcase
		end
	end

	// product follows the registers in the next cycle
	always_ff @(posedge clk) begin
		total_q <= TOTAL_W'(width_q) * TOTAL_W'(height_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			pos_q <= '0;
		end else begin
			if (pop) begin
				valid_q <= 1'b1;
				pos_q <= rec.last ? '0 : sum[POSITION_BITS-1:0];
			end else if (runs.ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			runs.first_code <= rec.c1;
			runs.second_code <= rec.c2;
			runs.pixel_count <= rec.count;
			runs.start_offset <= start_ext[START_W-1:0];
			runs.image_done <= (sum >= SUM_W'(total_q));
			runs.truncated <= rec.cut;
		end
	end

endmodule
